// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file iirdf1_chk.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IIRDF1_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted
`define IIRDF1_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: hdl/iirdf1_pkg.sv
// ---------------------------------------------------------------------------
// iirdf1_pkg
// Widths, microcode types and the control store of the direct form I filter.
// ---------------------------------------------------------------------------
`default_nettype none

package iirdf1_pkg;

  // Data widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned REG_W     = 2 * COEF_W;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned CFG_IDX_W = REG_IDX_W + 1;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned PROD_W    = COEF_W + SAMPLE_W;
  localparam int unsigned QUOT_W    = PROD_W - FRAC_W;
  localparam int          SMP_MAX   = 2 ** (SAMPLE_W - 1) - 1;

  // Taps
  localparam int unsigned TAPS_MAX = 8;
  localparam int unsigned TAPS_DEF = 8;
  localparam int unsigned TAP_W    = $clog2(TAPS_MAX);

  // Sequencer
  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] PC_FETCH = PC_W'(0);
  localparam logic [PC_W-1:0] PC_NUM   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_DEN   = PC_W'(1 + TAPS_MAX);
  localparam logic [PC_W-1:0] PC_DRAIN = PC_W'(1 + 2 * TAPS_MAX);
  localparam logic [PC_W-1:0] PC_FIN   = PC_W'(2 + 2 * TAPS_MAX);

  typedef enum logic [2:0] {
    OP_WAIT_IN,
    OP_MAC_NUM,
    OP_MAC_DEN,
    OP_DRAIN,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_TAP_LAST,
    JMP_ALWAYS
  } jmp_e;

  typedef struct packed {
    op_e              op;
    logic [TAP_W-1:0] tap;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_e              op;
    logic [TAP_W-1:0] tap;
    logic             fire;
  } ctrl_t;

  function automatic uword_t mk_uw(op_e op, int unsigned tap, jmp_e jmp,
                                   logic [PC_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.tap    = TAP_W'(tap);
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // Control store: fetch, numerator taps, denominator taps, drain, finish
  function automatic uword_t prog_rom(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = mk_uw(OP_WAIT_IN, 0, JMP_NEXT,     PC_FETCH);
      5'd1:    w = mk_uw(OP_MAC_NUM, 0, JMP_TAP_LAST, PC_DEN);
      5'd2:    w = mk_uw(OP_MAC_NUM, 1, JMP_TAP_LAST, PC_DEN);
      5'd3:    w = mk_uw(OP_MAC_NUM, 2, JMP_TAP_LAST, PC_DEN);
      5'd4:    w = mk_uw(OP_MAC_NUM, 3, JMP_TAP_LAST, PC_DEN);
      5'd5:    w = mk_uw(OP_MAC_NUM, 4, JMP_TAP_LAST, PC_DEN);
      5'd6:    w = mk_uw(OP_MAC_NUM, 5, JMP_TAP_LAST, PC_DEN);
      5'd7:    w = mk_uw(OP_MAC_NUM, 6, JMP_TAP_LAST, PC_DEN);
      5'd8:    w = mk_uw(OP_MAC_NUM, 7, JMP_TAP_LAST, PC_DEN);
      5'd9:    w = mk_uw(OP_MAC_DEN, 0, JMP_TAP_LAST, PC_DRAIN);
      5'd10:   w = mk_uw(OP_MAC_DEN, 1, JMP_TAP_LAST, PC_DRAIN);
      5'd11:   w = mk_uw(OP_MAC_DEN, 2, JMP_TAP_LAST, PC_DRAIN);
      5'd12:   w = mk_uw(OP_MAC_DEN, 3, JMP_TAP_LAST, PC_DRAIN);
      5'd13:   w = mk_uw(OP_MAC_DEN, 4, JMP_TAP_LAST, PC_DRAIN);
      5'd14:   w = mk_uw(OP_MAC_DEN, 5, JMP_TAP_LAST, PC_DRAIN);
      5'd15:   w = mk_uw(OP_MAC_DEN, 6, JMP_TAP_LAST, PC_DRAIN);
      5'd16:   w = mk_uw(OP_MAC_DEN, 7, JMP_TAP_LAST, PC_DRAIN);
      5'd17:   w = mk_uw(OP_DRAIN,   0, JMP_NEXT,     PC_FETCH);
      5'd18:   w = mk_uw(OP_FINISH,  0, JMP_ALWAYS,   PC_FETCH);
      default: w = mk_uw(OP_DRAIN,   0, JMP_ALWAYS,   PC_FETCH);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/iirdf1_if.sv
// ---------------------------------------------------------------------------
// iirdf1_if
// Valid/ready channels of the filter: sample in, sample out, coefficient write.
// ---------------------------------------------------------------------------
`default_nettype none

// Input sample channel
interface iirdf1_in_if import iirdf1_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       buffer_start;

  modport source (output valid, sample_in, buffer_start, input ready);
  modport sink   (input valid, sample_in, buffer_start, output ready);
endinterface

// Filtered sample channel
interface iirdf1_out_if import iirdf1_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// Coefficient register write channel
interface iirdf1_cfg_if import iirdf1_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/iir_direct_form_one_filter_top.sv
// ---------------------------------------------------------------------------
// iir_direct_form_one_filter_top
// Direct form I IIR filter on signed 16-bit samples, Q8.24 coefficients.
// ---------------------------------------------------------------------------
// One item in gives one item out: y = sum b_k*x[n-k] - sum a_k*y[n-k], each
// product truncated toward zero and saturated to 16 bits, terms that would
// overflow a 16-bit running sum skipped, the difference wrapped. buffer_start
// clears both histories before the sample is used. From acceptance to the
// next acceptance an item goes through one fetch step, one multiply per
// numerator and denominator tap through the single shared 32x16 multiplier,
// one step to drain its pipeline register and one to write the result. The
// result waits in an output register while the next item is taken; the
// finish step holds only if that register is full and not being read.
// Coefficient writes are always ready; indexes past the eighth are ignored.
`default_nettype none

module iir_direct_form_one_filter_top import iirdf1_pkg::*; #(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iirdf1_in_if.sink    in_ch,
  iirdf1_out_if.source out_ch,
  iirdf1_cfg_if.sink   cfg_ch
);

  ctrl_t ctrl;
  logic  out_hold;

  assign cfg_ch.ready = 1'b1;

  // Sequencer
  iirdf1_seq #(
    .TAPS (TAPS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .out_hold_i (out_hold),
    .in_ready_o (in_ch.ready),
    .ctrl_o     (ctrl)
  );

  // Datapath
  iirdf1_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .sample_i       (in_ch.sample_in),
    .buffer_start_i (in_ch.buffer_start),
    .cfg_we_i       (cfg_ch.valid),
    .cfg_idx_i      (cfg_ch.index),
    .cfg_data_i     (cfg_ch.data),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .sample_o       (out_ch.sample_out),
    .out_hold_o     (out_hold)
  );

endmodule

`default_nettype wire

// File: hdl/iirdf1_dp.sv
// ---------------------------------------------------------------------------
// iirdf1_dp
// Filter datapath: coefficient registers, histories, shared multiplier,
// saturating accumulators and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module iirdf1_dp import iirdf1_pkg::*; #(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       buffer_start_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [REG_W-1:0]           cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       out_hold_o
);

  localparam logic signed [QUOT_W-1:0] QMax = QUOT_W'(SMP_MAX);
  localparam logic signed [QUOT_W-1:0] QMin = QUOT_W'(-SMP_MAX - 1);
  localparam logic [PROD_W-1:0] FracMask = PROD_W'((1 << FRAC_W) - 1);

  logic [REG_W-1:0]           coef_q [NUM_REGS];
  logic signed [SAMPLE_W-1:0] xh_q [TAPS];
  logic signed [SAMPLE_W-1:0] yh_q [TAPS];
  logic signed [SAMPLE_W-1:0] sx_q, sy_q, out_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       acc_en_q, acc_den_q, out_valid_q;

  logic                       is_mac, is_den, accept, finish;
  logic [REG_IDX_W-1:0]       reg_sel;
  logic [REG_W-1:0]           coef_word;
  logic signed [COEF_W-1:0]   coef_s;
  logic signed [SAMPLE_W-1:0] smp_s;
  logic signed [PROD_W-1:0]   prod_d;
  logic [PROD_W-1:0]          prod_adj;
  logic signed [QUOT_W-1:0]   quot;
  logic signed [SAMPLE_W-1:0] term, acc_sel, y_val;
  logic [SAMPLE_W:0]          sum;
  logic                       sum_ovf;

  assign is_den = (ctrl_i.op == OP_MAC_DEN);
  assign is_mac = (ctrl_i.op == OP_MAC_NUM) || is_den;
  assign accept = ctrl_i.fire && (ctrl_i.op == OP_WAIT_IN);
  assign finish = ctrl_i.fire && (ctrl_i.op == OP_FINISH);

  // Coefficient register file, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) coef_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      coef_q[cfg_idx_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // Coefficient pick: two per register, denominator in the upper four
  assign reg_sel   = {is_den, ctrl_i.tap[TAP_W-1:1]};
  assign coef_word = coef_q[reg_sel];
  assign coef_s    = ctrl_i.tap[0] ? $signed(coef_word[REG_W-1:COEF_W])
                                   : $signed(coef_word[COEF_W-1:0]);

  // Sample pick from the history taps
  always_comb begin
    smp_s = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (ctrl_i.tap == TAP_W'(i)) smp_s = is_den ? yh_q[i] : xh_q[i];
    end
  end

  // Shared multiplier, registered
  assign prod_d = coef_s * smp_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q  <= 1'b0;
      acc_den_q <= 1'b0;
    end else begin
      acc_en_q  <= is_mac;
      acc_den_q <= is_den;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_mac) prod_q <= prod_d;
  end

  // Truncate toward zero, saturate, then add unless the sum leaves 16 bits
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? FracMask : '0);
  assign quot     = $signed(prod_adj[PROD_W-1:FRAC_W]);

  always_comb begin
    if (quot > QMax)      term = QMax[SAMPLE_W-1:0];
    else if (quot < QMin) term = QMin[SAMPLE_W-1:0];
    else                  term = quot[SAMPLE_W-1:0];
  end

  assign acc_sel = acc_den_q ? sy_q : sx_q;
  assign sum     = {acc_sel[SAMPLE_W-1], acc_sel} + {term[SAMPLE_W-1], term};
  assign sum_ovf = sum[SAMPLE_W] ^ sum[SAMPLE_W-1];
  assign y_val   = sx_q - sy_q;

  // Accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
    end else if (accept) begin
      sx_q <= '0;
      sy_q <= '0;
    end else if (acc_en_q && !sum_ovf) begin
      if (acc_den_q) sy_q <= $signed(sum[SAMPLE_W-1:0]);
      else           sx_q <= $signed(sum[SAMPLE_W-1:0]);
    end
  end

  // Histories: x shifts in on accept, y on finish; buffer start clears both
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else if (accept) begin
      xh_q[0] <= sample_i;
      for (int i = 1; i < TAPS; i++) xh_q[i] <= buffer_start_i ? '0 : xh_q[i-1];
      if (buffer_start_i) begin
        for (int i = 0; i < TAPS; i++) yh_q[i] <= '0;
      end
    end else if (finish) begin
      yh_q[0] <= y_val;
      for (int i = 1; i < TAPS; i++) yh_q[i] <= yh_q[i-1];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) out_q <= y_val;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;
  assign out_hold_o  = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// File: hdl/iirdf1_seq.sv
// ---------------------------------------------------------------------------
// iirdf1_seq
// Microcode sequencer: step counter over the control store, with waits on
// the handshakes and a jump after the last configured tap.
// ---------------------------------------------------------------------------
`default_nettype none

module iirdf1_seq import iirdf1_pkg::*; #(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_hold_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            fire;

  assign uw = prog_rom(pc_q);

  // Output decode: a step fires unless it waits on a handshake
  always_comb begin
    unique case (uw.op)
      OP_WAIT_IN: fire = in_valid_i;
      OP_FINISH:  fire = !out_hold_i;
      default:    fire = 1'b1;
    endcase
    ctrl_o.op   = uw.op;
    ctrl_o.tap  = uw.tap;
    ctrl_o.fire = fire;
    in_ready_o  = (uw.op == OP_WAIT_IN);
  end

  // Next step
  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      unique case (uw.jmp)
        JMP_TAP_LAST: pc_d = (uw.tap == TAP_W'(TAPS - 1)) ? uw.target : pc_q + 1'b1;
        JMP_ALWAYS:   pc_d = uw.target;
        default:      pc_d = pc_q + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pc_q <= PC_FETCH;
    else         pc_q <= pc_d;
  end

endmodule

`default_nettype wire

// File: hdl/iirdf1_chk.sv
// ---------------------------------------------------------------------------
// iirdf1_chk
// Port-level checks of the filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iirdf1_chk import iirdf1_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] sample_out_i,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i
);

  // Coefficient writes never stall
  `IIRDF1_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i)

  // One item at a time: no acceptance right after an acceptance
  `IIRDF1_ASSERT_NEXT(a_in_gap, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A result never appears the cycle after its item was taken
  `IIRDF1_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i))

  // A stalled result holds
  `IIRDF1_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(sample_out_i))

endmodule

bind iir_direct_form_one_filter_top iirdf1_chk u_iirdf1_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .sample_out_i (out_ch.sample_out),
  .cfg_valid_i  (cfg_ch.valid),
  .cfg_ready_i  (cfg_ch.ready)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct form I IIR filter. A clocked driver feeds
// samples and coefficient writes from a queue of pending items, a bit-accurate
// filter model predicts every output sample, and a clocked monitor compares
// each accepted output with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import iirdf1_pkg::*;

  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned ITEM_CYCLES  = 2 * TAPS_DEF + 3;
  localparam int unsigned TAIL_CYCLES  = 4 * ITEM_CYCLES;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 136;

  // Q8.24 coefficient values
  localparam logic [COEF_W-1:0] Q_ONE      = 32'h0100_0000;
  localparam logic [COEF_W-1:0] Q_HALF     = 32'h0080_0000;
  localparam logic [COEF_W-1:0] Q_QUARTER  = 32'h0040_0000;
  localparam logic [COEF_W-1:0] Q_NEG_ONE  = 32'hFF00_0000;
  localparam logic [COEF_W-1:0] Q_NEG_HALF = 32'hFF80_0000;
  localparam logic [COEF_W-1:0] Q_LSB      = 32'h0000_0001;
  localparam logic [COEF_W-1:0] Q_NEG_LSB  = 32'hFFFF_FFFF;
  localparam logic [COEF_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] Q_MIN      = 32'h8000_0000;
  localparam logic [COEF_W-1:0] Q_ZERO     = '0;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_W'(SMP_MAX);
  localparam logic signed [SAMPLE_W-1:0] S_MIN = SAMPLE_W'(-SMP_MAX - 1);

  // Coefficient register indexes; anything from NUM_REGS up is unmapped
  typedef enum int {
    R_NUM01, R_NUM23, R_NUM45, R_NUM67,
    R_DEN12, R_DEN34, R_DEN56, R_DEN78
  } coef_reg_e;
  localparam int unsigned IDX_FIRST_UNMAPPED = NUM_REGS;
  localparam int unsigned IDX_LAST           = 2 ** CFG_IDX_W - 1;

  typedef enum int {ACT_SAMPLE, ACT_COEF, ACT_QUIESCE, ACT_PACE} act_e;

  typedef enum int {
    STY_UNIT, STY_WILD, STY_POS_FULL, STY_NEG_FULL, STY_FIR, STY_FINE
  } coef_style_e;

  typedef struct {
    act_e                        kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        start;
    logic [CFG_IDX_W-1:0]        idx;
    logic [REG_W-1:0]            data;
    int                          src_pct;
    int                          rcv_pct;
  } stim_t;

  logic clk_i;
  logic rst_ni;

  iirdf1_in_if  in_ch ();
  iirdf1_out_if out_ch ();
  iirdf1_cfg_if cfg_ch ();

  iir_direct_form_one_filter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  stim_t                      pending_items[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];

  // Filter model state
  logic [REG_W-1:0]           coef_bank [NUM_REGS];
  logic signed [SAMPLE_W-1:0] x_hist [TAPS_DEF-1];
  logic signed [SAMPLE_W-1:0] y_hist [TAPS_DEF];

  int   n_filtered   = 0;
  int   n_checked    = 0;
  int   n_starts     = 0;
  int   n_writes     = 0;
  int   n_errors     = 0;
  int   src_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic stim_done    = 1'b0;

  // Coefficient number n: b0..b7 then a1..a8, two per register
  function automatic logic signed [COEF_W-1:0] coef_of(int n);
    return coef_bank[n >> 1][(n & 1) * COEF_W +: COEF_W];
  endfunction

  // Product truncated toward zero, then clamped to the sample range
  function automatic logic signed [SAMPLE_W-1:0] scaled_term(
      logic signed [COEF_W-1:0] c, logic signed [SAMPLE_W-1:0] s);
    longint p;
    longint q;
    p = longint'(c) * longint'(s);
    if (p < 0) q = -((-p) >>> FRAC_W);
    else q = p >>> FRAC_W;
    if (q > SMP_MAX) q = SMP_MAX;
    else if (q < -SMP_MAX - 1) q = -SMP_MAX - 1;
    return SAMPLE_W'(q);
  endfunction

  // A term that would push the running sum out of range is dropped
  function automatic logic signed [SAMPLE_W-1:0] add_or_skip(
      logic signed [SAMPLE_W-1:0] acc, logic signed [SAMPLE_W-1:0] term);
    int s;
    s = int'(acc) + int'(term);
    if (s > SMP_MAX || s < -SMP_MAX - 1) return acc;
    return SAMPLE_W'(s);
  endfunction

  // Run one sample through the model and queue the output it must produce
  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] x, input logic start);
    logic signed [SAMPLE_W-1:0] num_sum;
    logic signed [SAMPLE_W-1:0] den_sum;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] xv;
    if (start) begin
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
    end
    num_sum = '0;
    den_sum = '0;
    for (int k = 0; k < TAPS_DEF; k++) begin
      xv = (k == 0) ? x : x_hist[k-1];
      num_sum = add_or_skip(num_sum, scaled_term(coef_of(k), xv));
    end
    for (int k = 1; k <= TAPS_DEF; k++) begin
      den_sum = add_or_skip(den_sum, scaled_term(coef_of(TAPS_DEF + k - 1), y_hist[k-1]));
    end
    y = num_sum - den_sum;
    for (int k = TAPS_DEF - 1; k > 0; k--) begin
      if (k < TAPS_DEF - 1) x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    expected_samples.insert(expected_samples.size(), y);
  endtask

  // Queue builders
  function automatic void add_sample(logic signed [SAMPLE_W-1:0] x, logic start);
    stim_t s;
    s = '{kind: ACT_SAMPLE, default: 0};
    s.sample = x;
    s.start  = start;
    pending_items.insert(pending_items.size(), s);
  endfunction

  function automatic void add_coef(int idx, logic [COEF_W-1:0] hi, logic [COEF_W-1:0] lo);
    stim_t s;
    s = '{kind: ACT_COEF, default: 0};
    s.idx  = CFG_IDX_W'(idx);
    s.data = {hi, lo};
    pending_items.insert(pending_items.size(), s);
  endfunction

  function automatic void add_quiesce();
    stim_t s;
    s = '{kind: ACT_QUIESCE, default: 0};
    pending_items.insert(pending_items.size(), s);
  endfunction

  function automatic void add_pace(int src_pct, int rcv_pct);
    stim_t s;
    s = '{kind: ACT_PACE, default: 0};
    s.src_pct = src_pct;
    s.rcv_pct = rcv_pct;
    pending_items.insert(pending_items.size(), s);
  endfunction

  function automatic logic [COEF_W-1:0] draw_coef(coef_style_e sty, bit den);
    int span;
    case (sty)
      STY_UNIT:     span = den ? (1 << 23) : (1 << 24);
      STY_FINE:     span = 1 << 16;
      STY_FIR:      span = den ? 0 : (1 << 24);
      STY_POS_FULL: return Q_MAX;
      STY_NEG_FULL: return Q_MIN;
      default:      return $urandom;
    endcase
    return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          3:       return '1;
          default: return SAMPLE_W'(1);
        endcase
      end
      1, 2:    return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Driver: one item per handshake; writes and pauses only once all is drained
  always @(posedge clk_i) begin
    logic  in_acc;
    logic  cfg_acc;
    logic  quiet;
    logic  in_go;
    logic  cfg_go;
    stim_t nxt;
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
    end else begin
      in_acc  = in_ch.valid && in_ch.ready;
      cfg_acc = cfg_ch.valid && cfg_ch.ready;
      if (in_acc) begin
        filter_sample(in_ch.sample_in, in_ch.buffer_start);
        n_filtered <= n_filtered + 1;
        if (in_ch.buffer_start) n_starts <= n_starts + 1;
      end
      if (cfg_acc) begin
        if (cfg_ch.index < NUM_REGS) coef_bank[cfg_ch.index[REG_IDX_W-1:0]] = cfg_ch.data;
        n_writes++;
      end
      quiet = (n_filtered + (in_acc ? 1 : 0)) == n_checked;
      if ((!in_ch.valid || in_acc) && (!cfg_ch.valid || cfg_acc)) begin
        in_go  = 1'b0;
        cfg_go = 1'b0;
        if (pending_items.size() == 0) begin
          if (quiet) stim_done <= 1'b1;
        end else begin
          nxt = pending_items[0];
          case (nxt.kind)
            ACT_SAMPLE: begin
              if ($urandom_range(99) >= src_idle_pct) begin
                in_go = 1'b1;
                in_ch.sample_in    <= nxt.sample;
                in_ch.buffer_start <= nxt.start;
                pending_items.delete(0);
              end
            end
            ACT_COEF: begin
              if (quiet) begin
                cfg_go = 1'b1;
                cfg_ch.index <= nxt.idx;
                cfg_ch.data  <= nxt.data;
                pending_items.delete(0);
              end
            end
            ACT_QUIESCE: begin
              if (quiet) pending_items.delete(0);
            end
            default: begin
              src_idle_pct = nxt.src_pct;
              rcv_idle_pct <= nxt.rcv_pct;
              pending_items.delete(0);
            end
          endcase
        end
        in_ch.valid  <= in_go;
        cfg_ch.valid <= cfg_go;
      end
    end
  end

  // Monitor: compare each output item with the oldest prediction
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample_out expected none, actual %0d", $time, out_ch.sample_out);
          n_errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.sample_out !== want) begin
            $display("%0t: sample_out expected %0d, actual %0d",
                     $time, want, out_ch.sample_out);
            n_errors++;
          end
        end
        n_checked <= n_checked + 1;
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Run limit: roughly ten times the slowest expected run
  initial begin
    #5_000_000;
    $display("iir_direct_form_one_filter_top: mismatch");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    int          left;
    int          len;
    bit          held;
    coef_style_e sty;

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample_in    = '0;
    in_ch.buffer_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    foreach (coef_bank[i]) coef_bank[i] = '0;
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;

    // Directed: zero coefficients after reset, then saturation, skipped terms,
    // truncation of tiny products, buffer restarts and unmapped writes
    add_pace(12, 46);
    add_sample(S_MAX, 1'b1);
    add_coef(R_NUM01, Q_HALF, Q_ONE);
    add_coef(R_NUM23, Q_NEG_ONE, Q_MAX);
    add_coef(R_NUM45, Q_NEG_LSB, Q_LSB);
    add_coef(R_NUM67, Q_ZERO, Q_MIN);
    add_coef(R_DEN12, Q_QUARTER, Q_NEG_HALF);
    add_coef(R_DEN34, Q_MAX, Q_ZERO);
    add_coef(R_DEN56, Q_ZERO, Q_ZERO);
    add_coef(R_DEN78, Q_ZERO, Q_MIN);
    add_coef(IDX_FIRST_UNMAPPED, Q_NEG_LSB, Q_NEG_LSB);
    add_coef(IDX_LAST, Q_NEG_LSB, Q_NEG_LSB);
    add_sample(S_MAX, 1'b1);
    add_sample(S_MIN, 1'b0);
    add_sample('0, 1'b0);
    add_sample('1, 1'b0);
    add_sample(SAMPLE_W'(1), 1'b0);
    add_sample(S_MAX, 1'b0);
    add_sample(S_MAX, 1'b0);
    add_sample(S_MIN, 1'b0);
    add_sample(S_MIN, 1'b0);
    add_sample(SAMPLE_W'(100), 1'b0);
    add_sample(SAMPLE_W'(-100), 1'b0);
    add_sample(SAMPLE_W'(12345), 1'b1);
    add_sample('0, 1'b0);
    add_sample(S_MIN, 1'b1);
    add_sample(S_MAX, 1'b0);
    add_sample('0, 1'b0);
    add_quiesce();
    add_coef(R_NUM01, Q_ZERO, Q_ONE);
    add_sample(S_MIN, 1'b1);
    add_sample(S_MAX, 1'b0);
    add_sample('1, 1'b0);

    // Random: one coefficient setting per phase, samples in buffers
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) add_pace(46, 12);
      if (ph == 2 * PHASES / 3) add_pace(0, 0);
      sty = coef_style_e'(ph % 6);
      for (int r = 0; r < NUM_REGS; r++) begin
        add_coef(r, draw_coef(sty, r >= R_DEN12), draw_coef(sty, r >= R_DEN12));
      end
      if (ph % 3 == 1) begin
        add_coef($urandom_range(IDX_FIRST_UNMAPPED, IDX_LAST), $urandom, $urandom);
      end
      left = PHASE_ITEMS;
      held = 1'b0;
      while (left > 0) begin
        len = $urandom_range(4, 48);
        if (len > left) len = left;
        for (int i = 0; i < len; i++) begin
          add_sample(draw_sample(), (i == 0) || ($urandom_range(49) == 0));
        end
        left -= len;
        // Let the filter run dry once in the middle of the phase
        if (!held && left > 0 && left <= PHASE_ITEMS / 2) begin
          add_quiesce();
          held = 1'b1;
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_done);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_samples.size() != 0) begin
      $display("%0t: %0d predicted samples never came out", $time, expected_samples.size());
      n_errors++;
    end
    $display("filtered %0d samples in %0d buffers, %0d register writes, %0d settings",
             n_filtered, n_starts, n_writes, PHASES + 2);
    $display("outputs checked %0d, errors %0d", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("iir_direct_form_one_filter_top: match");
    end else begin
      $display("iir_direct_form_one_filter_top: mismatch");
    end
    $finish;
  end

endmodule
